FILE: rtl/cvmb_pkg.sv
package cvmb_pkg;

  // normalised axis component: signed, magnitude at most 1.0 in q16.16
  localparam int UnitW = 18;
  typedef logic signed [UnitW-1:0] unit_t;

  // 1.0 in q16.16, as carried on the column 3 entry
  localparam logic [16:0] OneQ16 = 17'd65536;

  // widths inside the normalise unit
  localparam int RootW = 32;
  localparam int SqW   = 64;
  localparam int NumW  = 48;
  localparam int QuoW  = 17;

endpackage

FILE: rtl/cvmb_norm.sv
module cvmb_norm import cvmb_pkg::*; #(
  parameter int W  = 32,
  parameter int SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [W-1:0] v_i [3],
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output unit_t               n_o [3],
  output logic                zero_o,
  output logic [SW-1:0]       side_o
);

  localparam int PW = $clog2(W);
  localparam logic [PW-1:0] PMid = PW'(31);
  localparam int SqSt = RootW;
  localparam int DvSt = QuoW;

  // stage a: sign and magnitude, largest magnitude
  logic [W-1:0] mag [3];
  logic [W-1:0] mx;
  logic         a_v_q;
  logic [2:0][W-1:0] a_u_q;
  logic [2:0]   a_neg_q;
  logic [W-1:0] a_m_q;
  logic [SW-1:0] a_side_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = v_i[i][W-1] ? (~v_i[i] + 1'b1) : v_i[i];
    end
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (en_i) a_v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        a_u_q[i]   <= mag[i];
        a_neg_q[i] <= v_i[i][W-1];
      end
      a_m_q    <= mx;
      a_side_q <= side_i;
    end
  end

  // stage b: position of the leading one
  logic [PW-1:0] lead;
  logic          b_v_q;
  logic [2:0][W-1:0] b_u_q;
  logic [2:0]    b_neg_q;
  logic [W-1:0]  b_m_q;
  logic [PW-1:0] b_p_q;
  logic [SW-1:0] b_side_q;

  always_comb begin
    lead = '0;
    for (int i = 0; i < W; i++) begin
      if (a_m_q[i]) lead = PW'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_v_q <= 1'b0;
    else if (en_i) b_v_q <= a_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_u_q    <= a_u_q;
      b_neg_q  <= a_neg_q;
      b_m_q    <= a_m_q;
      b_p_q    <= lead;
      b_side_q <= a_side_q;
    end
  end

  // stage c: bring the leading one to bit 31
  logic [W-1:0]  sh_w [4];
  logic [PW-1:0] rsh, lsh;
  logic          c_v_q, c_lt_q, c_zero_q;
  logic [2:0][31:0] c_u_q;
  logic [31:0]   c_m_q;
  logic [2:0]    c_neg_q;
  logic [SW-1:0] c_side_q;

  always_comb begin
    rsh = b_p_q - PMid;
    lsh = PMid - b_p_q;
    for (int i = 0; i < 3; i++) begin
      sh_w[i] = (b_p_q >= PMid) ? (b_u_q[i] >> rsh) : (b_u_q[i] << lsh);
    end
    sh_w[3] = (b_p_q >= PMid) ? (b_m_q >> rsh) : (b_m_q << lsh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= 1'b0;
    else if (en_i) c_v_q <= b_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) c_u_q[i] <= sh_w[i][31:0];
      c_m_q    <= sh_w[3][31:0];
      c_lt_q   <= (b_p_q < PMid);
      c_zero_q <= (b_m_q == '0);
      c_neg_q  <= b_neg_q;
      c_side_q <= b_side_q;
    end
  end

  // stage d: final step so the largest lands in [2^30, 2^31]
  logic          extra;
  logic          d_v_q, d_zero_q;
  logic [2:0][31:0] d_u_q;
  logic [2:0]    d_neg_q;
  logic [SW-1:0] d_side_q;

  assign extra = c_lt_q || (c_m_q != 32'h8000_0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_v_q <= 1'b0;
    else if (en_i) d_v_q <= c_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) d_u_q[i] <= extra ? (c_u_q[i] >> 1) : c_u_q[i];
      d_zero_q <= c_zero_q;
      d_neg_q  <= c_neg_q;
      d_side_q <= c_side_q;
    end
  end

  // stage e: squares
  logic          e_v_q, e_zero_q;
  logic [2:0][31:0] e_u_q;
  logic [2:0][SqW-1:0] e_sq_q;
  logic [2:0]    e_neg_q;
  logic [SW-1:0] e_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_v_q <= 1'b0;
    else if (en_i) e_v_q <= d_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) e_sq_q[i] <= SqW'(d_u_q[i]) * SqW'(d_u_q[i]);
      e_u_q    <= d_u_q;
      e_zero_q <= d_zero_q;
      e_neg_q  <= d_neg_q;
      e_side_q <= d_side_q;
    end
  end

  // square root ladder: index 0 holds the sum, one root bit per stage after
  logic                sv_q    [SqSt+1];
  logic [SqW-1:0]      srem_q  [SqSt+1];
  logic [RootW-1:0]    sroot_q [SqSt+1];
  logic [2:0][31:0]    su_q    [SqSt+1];
  logic [2:0]          sneg_q  [SqSt+1];
  logic                szero_q [SqSt+1];
  logic [SW-1:0]       sside_q [SqSt+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (en_i) sv_q[0] <= e_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srem_q[0]  <= e_sq_q[0] + e_sq_q[1] + e_sq_q[2];
      sroot_q[0] <= '0;
      su_q[0]    <= e_u_q;
      sneg_q[0]  <= e_neg_q;
      szero_q[0] <= e_zero_q;
      sside_q[0] <= e_side_q;
    end
  end

  for (genvar k = 0; k < SqSt; k++) begin : g_sqrt
    localparam int Bit = RootW - 1 - k;
    logic [SqW+1:0] delta;
    logic           ge;

    always_comb begin
      delta = ((SqW+2)'(sroot_q[k]) << (Bit + 1)) + ((SqW+2)'(1) << (2 * Bit));
      ge    = (SqW+2)'(srem_q[k]) >= delta;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else if (en_i) sv_q[k+1] <= sv_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srem_q[k+1]  <= ge ? SqW'((SqW+2)'(srem_q[k]) - delta) : srem_q[k];
        sroot_q[k+1] <= ge ? (sroot_q[k] | (RootW'(1) << Bit)) : sroot_q[k];
        su_q[k+1]    <= su_q[k];
        sneg_q[k+1]  <= sneg_q[k];
        szero_q[k+1] <= szero_q[k];
        sside_q[k+1] <= sside_q[k];
      end
    end
  end

  // divide ladder: index 0 holds the rounded numerators, one quotient bit per stage
  logic                dv_q    [DvSt+1];
  logic [2:0][NumW-1:0] drem_q [DvSt+1];
  logic [2:0][QuoW-1:0] dquo_q [DvSt+1];
  logic [RootW-1:0]    dlen_q  [DvSt+1];
  logic [2:0]          dneg_q  [DvSt+1];
  logic                dzero_q [DvSt+1];
  logic [SW-1:0]       dside_q [DvSt+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else if (en_i) dv_q[0] <= sv_q[SqSt];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= {su_q[SqSt][i], 16'b0} + NumW'(sroot_q[SqSt] >> 1);
      end
      dquo_q[0]  <= '0;
      dlen_q[0]  <= sroot_q[SqSt];
      dneg_q[0]  <= sneg_q[SqSt];
      dzero_q[0] <= szero_q[SqSt];
      dside_q[0] <= sside_q[SqSt];
    end
  end

  for (genvar j = 0; j < DvSt; j++) begin : g_div
    localparam int Bit = QuoW - 1 - j;
    logic [NumW:0] dd;
    logic [2:0]    ge;

    always_comb begin
      dd = (NumW+1)'(dlen_q[j]) << Bit;
      for (int i = 0; i < 3; i++) ge[i] = (NumW+1)'(drem_q[j][i]) >= dd;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j+1] <= 1'b0;
      else if (en_i) dv_q[j+1] <= dv_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          drem_q[j+1][i] <= ge[i] ? NumW'((NumW+1)'(drem_q[j][i]) - dd) : drem_q[j][i];
          dquo_q[j+1][i] <= ge[i] ? (dquo_q[j][i] | (QuoW'(1) << Bit)) : dquo_q[j][i];
        end
        dlen_q[j+1]  <= dlen_q[j];
        dneg_q[j+1]  <= dneg_q[j];
        dzero_q[j+1] <= dzero_q[j];
        dside_q[j+1] <= dside_q[j];
      end
    end
  end

  // output stage: sign back on, zero vector forced to zero
  unit_t qs [3];
  logic  o_v_q, o_zero_q;
  unit_t o_n_q [3];
  logic [SW-1:0] o_side_q;

  always_comb begin
    for (int i = 0; i < 3; i++) qs[i] = unit_t'({1'b0, dquo_q[DvSt][i]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_v_q <= 1'b0;
    else if (en_i) o_v_q <= dv_q[DvSt];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        o_n_q[i] <= dzero_q[DvSt] ? '0 : (dneg_q[DvSt][i] ? -qs[i] : qs[i]);
      end
      o_zero_q <= dzero_q[DvSt];
      o_side_q <= dside_q[DvSt];
    end
  end

  assign valid_o = o_v_q;
  assign n_o     = o_n_q;
  assign zero_o  = o_zero_q;
  assign side_o  = o_side_q;

endmodule

FILE: rtl/camera_view_matrix_build.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   look, right, eye vectors (9 x 32 bit)
// m_axis    out  m_axis_tvalid/m_axis_tready   row, col0..col3; tuser degenerate; tlast
//
// an input word can enter every cycle while the output buffer is idle; each item leaves
// as four output words, and the output row sequencer holds the whole pipeline until
// the last of them is taken
// most of the pipeline registers sit in the bit-per-stage square root and divide ladders
// of the three normalise units
// reset clears only the valid bits and the row counter
// a stall on the output freezes the whole pipeline; nothing is dropped or repeated
module camera_view_matrix_build import cvmb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // look_x, look_y, look_z, right_x, right_y, right_z, eye_x, eye_y, eye_z
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row, col0, col1, col2, col3, zero fill
  output logic [119:0] m_axis_tdata,
  // degenerate
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam logic [1:0] RowLast = 2'd3;

  typedef logic [2:0][31:0]       word3_t;
  typedef logic [2:0][UnitW-1:0]  unit3_t;

  typedef struct packed {
    word3_t rt;
    word3_t eye;
  } side1_t;

  typedef struct packed {
    unit3_t lk;
    word3_t eye;
    logic   deg;
  } side2_t;

  typedef struct packed {
    unit3_t lk;
    unit3_t up;
    word3_t eye;
    logic   deg;
  } side3_t;

  // global advance: the output buffer is free or hands over its last row now
  logic       en;
  logic       ob_v_q;
  logic [1:0] ob_row_q;

  assign en = !ob_v_q || (m_axis_tready && (ob_row_q == RowLast));
  assign s_axis_tready = en;

  // normalise look
  logic signed [31:0] lk_in [3];
  side1_t s1_in, s1_out;
  logic   n1_v, n1_zero;
  unit_t  n1_n [3];

  always_comb begin
    for (int i = 0; i < 3; i++) lk_in[i] = signed'(s_axis_tdata[32*i +: 32]);
    s1_in.rt  = s_axis_tdata[191:96];
    s1_in.eye = s_axis_tdata[287:192];
  end

  cvmb_norm #(.W(32), .SW($bits(side1_t))) u_norm_look (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid), .v_i(lk_in), .side_i(s1_in),
    .valid_o(n1_v), .n_o(n1_n), .zero_o(n1_zero), .side_o(s1_out)
  );

  // up direction: look cross right, products then differences
  logic signed [49:0] x1_p_q [6];
  logic               x1_v_q;
  unit3_t             x1_lk_q;
  word3_t             x1_eye_q;
  logic               x1_deg_q;
  logic signed [31:0] rt_in [3];

  always_comb begin
    for (int i = 0; i < 3; i++) rt_in[i] = signed'(s1_out.rt[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) x1_v_q <= 1'b0;
    else if (en) x1_v_q <= n1_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_p_q[0] <= 50'(n1_n[1]) * 50'(rt_in[2]);
      x1_p_q[1] <= 50'(n1_n[2]) * 50'(rt_in[1]);
      x1_p_q[2] <= 50'(n1_n[2]) * 50'(rt_in[0]);
      x1_p_q[3] <= 50'(n1_n[0]) * 50'(rt_in[2]);
      x1_p_q[4] <= 50'(n1_n[0]) * 50'(rt_in[1]);
      x1_p_q[5] <= 50'(n1_n[1]) * 50'(rt_in[0]);
      for (int i = 0; i < 3; i++) x1_lk_q[i] <= n1_n[i];
      x1_eye_q <= s1_out.eye;
      x1_deg_q <= n1_zero;
    end
  end

  logic signed [50:0] x2_c_q [3];
  logic               x2_v_q;
  side2_t             s2_in, s2_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) x2_v_q <= 1'b0;
    else if (en) x2_v_q <= x1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_c_q[0] <= 51'(x1_p_q[0]) - 51'(x1_p_q[1]);
      x2_c_q[1] <= 51'(x1_p_q[2]) - 51'(x1_p_q[3]);
      x2_c_q[2] <= 51'(x1_p_q[4]) - 51'(x1_p_q[5]);
      s2_in.lk  <= x1_lk_q;
      s2_in.eye <= x1_eye_q;
      s2_in.deg <= x1_deg_q;
    end
  end

  logic  n2_v, n2_zero;
  unit_t n2_n [3];

  cvmb_norm #(.W(51), .SW($bits(side2_t))) u_norm_up (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(x2_v_q), .v_i(x2_c_q), .side_i(s2_in),
    .valid_o(n2_v), .n_o(n2_n), .zero_o(n2_zero), .side_o(s2_out)
  );

  // right direction: up cross look
  logic signed [35:0] y1_p_q [6];
  logic               y1_v_q;
  unit3_t             y1_lk_q, y1_up_q;
  word3_t             y1_eye_q;
  logic               y1_deg_q;
  unit_t              lk2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) lk2[i] = unit_t'(s2_out.lk[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) y1_v_q <= 1'b0;
    else if (en) y1_v_q <= n2_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y1_p_q[0] <= 36'(n2_n[1]) * 36'(lk2[2]);
      y1_p_q[1] <= 36'(n2_n[2]) * 36'(lk2[1]);
      y1_p_q[2] <= 36'(n2_n[2]) * 36'(lk2[0]);
      y1_p_q[3] <= 36'(n2_n[0]) * 36'(lk2[2]);
      y1_p_q[4] <= 36'(n2_n[0]) * 36'(lk2[1]);
      y1_p_q[5] <= 36'(n2_n[1]) * 36'(lk2[0]);
      for (int i = 0; i < 3; i++) y1_up_q[i] <= n2_n[i];
      y1_lk_q  <= s2_out.lk;
      y1_eye_q <= s2_out.eye;
      y1_deg_q <= s2_out.deg | n2_zero;
    end
  end

  logic signed [36:0] y2_c_q [3];
  logic               y2_v_q;
  side3_t             s3_in, s3_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) y2_v_q <= 1'b0;
    else if (en) y2_v_q <= y1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y2_c_q[0] <= 37'(y1_p_q[0]) - 37'(y1_p_q[1]);
      y2_c_q[1] <= 37'(y1_p_q[2]) - 37'(y1_p_q[3]);
      y2_c_q[2] <= 37'(y1_p_q[4]) - 37'(y1_p_q[5]);
      s3_in.lk  <= y1_lk_q;
      s3_in.up  <= y1_up_q;
      s3_in.eye <= y1_eye_q;
      s3_in.deg <= y1_deg_q;
    end
  end

  logic  n3_v, n3_zero;
  unit_t n3_n [3];

  cvmb_norm #(.W(37), .SW($bits(side3_t))) u_norm_right (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(y2_v_q), .v_i(y2_c_q), .side_i(s3_in),
    .valid_o(n3_v), .n_o(n3_n), .zero_o(n3_zero), .side_o(s3_out)
  );

  // translation: products of each axis with the eye
  logic signed [49:0] t1_p_q [3][3];
  logic               t1_v_q, t1_deg_q;
  unit3_t             t1_rt_q, t1_up_q, t1_lk_q;
  logic signed [31:0] eye3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) eye3[i] = signed'(s3_out.eye[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t1_v_q <= 1'b0;
    else if (en) t1_v_q <= n3_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t1_p_q[0][i] <= 50'(n3_n[i]) * 50'(eye3[i]);
        t1_p_q[1][i] <= 50'(unit_t'(s3_out.up[i])) * 50'(eye3[i]);
        t1_p_q[2][i] <= 50'(unit_t'(s3_out.lk[i])) * 50'(eye3[i]);
        t1_rt_q[i]   <= n3_n[i];
      end
      t1_up_q  <= s3_out.up;
      t1_lk_q  <= s3_out.lk;
      t1_deg_q <= s3_out.deg | n3_zero;
    end
  end

  // negate, round half up to q16.16 (floor of (-sum + 2^15) / 2^16)
  logic signed [51:0] tsum [3];
  logic signed [51:0] trnd [3];
  logic signed [35:0] t2_q_q [3];
  logic               t2_v_q, t2_deg_q;
  unit3_t             t2_rt_q, t2_up_q, t2_lk_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      tsum[a] = 52'(t1_p_q[a][0]) + 52'(t1_p_q[a][1]) + 52'(t1_p_q[a][2]);
      trnd[a] = -tsum[a] + 52'sd32768;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t2_v_q <= 1'b0;
    else if (en) t2_v_q <= t1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) t2_q_q[a] <= trnd[a][51:16];
      t2_rt_q  <= t1_rt_q;
      t2_up_q  <= t1_up_q;
      t2_lk_q  <= t1_lk_q;
      t2_deg_q <= t1_deg_q;
    end
  end

  // output buffer with saturated translations, then four rows
  logic [31:0] tsat [3];
  unit3_t      ob_rt_q, ob_up_q, ob_lk_q;
  logic [31:0] ob_t_q [3];
  logic        ob_deg_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (t2_q_q[a] > 36'sh0_7FFF_FFFF) tsat[a] = 32'h7FFF_FFFF;
      else if (t2_q_q[a] < -36'sh0_8000_0000) tsat[a] = 32'h8000_0000;
      else tsat[a] = t2_q_q[a][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_v_q   <= 1'b0;
      ob_row_q <= '0;
    end else if (en) begin
      ob_v_q   <= t2_v_q;
      ob_row_q <= '0;
    end else if (m_axis_tready) begin
      ob_row_q <= ob_row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ob_rt_q  <= t2_rt_q;
      ob_up_q  <= t2_up_q;
      ob_lk_q  <= t2_lk_q;
      ob_t_q   <= tsat;
      ob_deg_q <= t2_deg_q;
    end
  end

  logic [31:0] col0, col1, col2;
  logic [16:0] col3;

  always_comb begin
    if (ob_row_q == RowLast) begin
      col0 = ob_t_q[0];
      col1 = ob_t_q[1];
      col2 = ob_t_q[2];
      col3 = OneQ16;
    end else begin
      col0 = 32'(unit_t'(ob_rt_q[ob_row_q]));
      col1 = 32'(unit_t'(ob_up_q[ob_row_q]));
      col2 = 32'(unit_t'(ob_lk_q[ob_row_q]));
      col3 = '0;
    end
  end

  assign m_axis_tvalid = ob_v_q;
  assign m_axis_tdata  = {5'b0, col3, col2, col1, col0, ob_row_q};
  assign m_axis_tuser  = ob_deg_q;
  assign m_axis_tlast  = (ob_row_q == RowLast);

  // rows of one item stay together and count up without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (ob_row_q == $past(ob_row_q) + 2'd1))
    else $error("row sequence broken");

  // degenerate flag is the same on every row of an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tuser == $past(m_axis_tuser))
    else $error("degenerate flag changed inside an item");

  // no new item enters while the buffer still has rows to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("pipeline advanced mid item");

  // a finished item frees the buffer for the next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |-> s_axis_tready)
    else $error("buffer not released after last row");

endmodule
